// ===== rtl/gic_pkg.sv =====
// Shared types and constants of the gamepad input conditioner.
// No dependencies; imported by every module of the block.
package gic_pkg;

   localparam int PLAYERS = 4;
   localparam int BUTTONS = 16;
   localparam int PLAYER_W = $clog2(PLAYERS);
   localparam int BTN_W = $clog2(BUTTONS);
   localparam int TMR_DEPTH = PLAYERS * BUTTONS;
   localparam int TMR_AW = $clog2(TMR_DEPTH);
   localparam logic [15:0] BTN_MASK = 16'((32'd1 << BUTTONS) - 32'd1);

   localparam logic [15:0] DEAD_ZONE_RESET = 16'd13107;
   localparam logic [15:0] TAP_LIMIT_RESET = 16'd0;

   localparam logic REG_DEAD_ZONE = 1'b0;
   localparam logic REG_TAP_LIMIT = 1'b1;

   typedef struct packed {
      logic [1:0]        owner;
      logic [15:0]       buttons;
      logic [15:0]       press_edge;
      logic [15:0]       release_edge;
      logic [3:0]        trig_flags;
      logic [3:0][15:0]  sticks;
      logic [15:0]       elapsed;
   } gic_item_type;

endpackage

// ===== rtl/gamepad_input_conditioner.sv =====
// Gamepad input conditioner: one poll in, one conditioned result out.
// Depends on gic_pkg, gic_front, gic_queue and gic_back.
//
// Input: present a poll with req_push; it transfers when req_full is low.
// Output: a result waits on the rsp_ ports while rsp_empty is low and
// transfers on rsp_pop. Results come in poll order, one per poll.
// Configuration: csr_we writes csr_wdata to register csr_index
// (0 dead zone, 1 tap limit); write only while the block is idle.
// Sequence: the back end takes the poll from the queue, then gives each stick
// axis a set-up step, plus a pass of the shared restoring divider when it
// lies outside the dead zone (cut short when it saturates); the hold-timer
// sweep runs alongside, and the result register loads once both are done.
// The back end takes no new poll until its result has loaded; a two-entry
// queue lets the front accept polls meanwhile.
// Reset: all player state, timers and deflection flags read as zero,
// dead zone returns to 13107 and tap limit to zero; no clearing pass.
// A stalled receiver holds the result register; the back end then waits
// with its finished result and the queue fills, raising req_full.
module gamepad_input_conditioner (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [1:0]         req_player,
   input  logic               req_poll_ok,
   input  logic [15:0]        req_buttons,
   input  logic [7:0]         req_left_trigger,
   input  logic [7:0]         req_right_trigger,
   input  logic signed [15:0] req_left_x,
   input  logic signed [15:0] req_left_y,
   input  logic signed [15:0] req_right_x,
   input  logic signed [15:0] req_right_y,
   input  logic [15:0]        req_elapsed,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [1:0]         rsp_owner,
   output logic [15:0]        rsp_press_mask,
   output logic [15:0]        rsp_press_edge_mask,
   output logic [15:0]        rsp_release_mask,
   output logic [3:0]         rsp_trigger_flags,
   output logic signed [15:0] rsp_left_x_ratio,
   output logic signed [15:0] rsp_left_y_ratio,
   output logic signed [15:0] rsp_right_x_ratio,
   output logic signed [15:0] rsp_right_y_ratio,
   output logic [3:0]         rsp_stick_edge_flags,
   output logic [15:0]        rsp_tap_mask,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [15:0]        csr_wdata
);
   import gic_pkg::*;

   logic [15:0]  dead_zone_ff, tap_limit_ff;
   logic         q_push, q_pop, q_empty;
   gic_item_type push_item, pop_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_zone_ff <= DEAD_ZONE_RESET;
         tap_limit_ff <= TAP_LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_DEAD_ZONE: begin
               dead_zone_ff <= csr_wdata;
            end
            REG_TAP_LIMIT: begin
               tap_limit_ff <= csr_wdata;
            end
            default: begin
               dead_zone_ff <= dead_zone_ff;
            end
         endcase
      end
   end

   gic_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (req_push),
      .q_full        (req_full),
      .player        (req_player),
      .poll_ok       (req_poll_ok),
      .buttons       (req_buttons),
      .left_trigger  (req_left_trigger),
      .right_trigger (req_right_trigger),
      .left_x        (req_left_x),
      .left_y        (req_left_y),
      .right_x       (req_right_x),
      .right_y       (req_right_y),
      .elapsed       (req_elapsed),
      .q_push        (q_push),
      .q_item        (push_item)
   );

   gic_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (req_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_item  (pop_item)
   );

   gic_back u_back (
      .clock                (clock),
      .reset                (reset),
      .dead_zone            (dead_zone_ff),
      .tap_limit            (tap_limit_ff),
      .q_empty              (q_empty),
      .q_item               (pop_item),
      .q_pop                (q_pop),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_owner            (rsp_owner),
      .rsp_press_mask       (rsp_press_mask),
      .rsp_press_edge_mask  (rsp_press_edge_mask),
      .rsp_release_mask     (rsp_release_mask),
      .rsp_trigger_flags    (rsp_trigger_flags),
      .rsp_left_x_ratio     (rsp_left_x_ratio),
      .rsp_left_y_ratio     (rsp_left_y_ratio),
      .rsp_right_x_ratio    (rsp_right_x_ratio),
      .rsp_right_y_ratio    (rsp_right_y_ratio),
      .rsp_stick_edge_flags (rsp_stick_edge_flags),
      .rsp_tap_mask         (rsp_tap_mask)
   );

endmodule

// ===== rtl/gic_front.sv =====
// Front end: accepts polls, keeps per-player button, trigger and stick state.
// Depends on gic_pkg; feeds gic_queue.
module gic_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic                  q_full,
   input  logic [1:0]            player,
   input  logic                  poll_ok,
   input  logic [15:0]           buttons,
   input  logic [7:0]            left_trigger,
   input  logic [7:0]            right_trigger,
   input  logic [15:0]           left_x,
   input  logic [15:0]           left_y,
   input  logic [15:0]           right_x,
   input  logic [15:0]           right_y,
   input  logic [15:0]           elapsed,
   output logic                  q_push,
   output gic_pkg::gic_item_type q_item
);
   import gic_pkg::*;

   logic [15:0]       btn_ff [PLAYERS];
   logic [3:0][15:0]  stk_ff [PLAYERS];
   logic [1:0]        trg_ff [PLAYERS];
   logic [35:0]       edg_ff [PLAYERS];

   logic [PLAYER_W-1:0] p;
   logic [15:0]         btn_in;
   logic [3:0][15:0]    stk_in;
   logic [1:0]          trg_in;
   logic [35:0]         edg_in;
   logic                lt, rt;
   logic [3:0]          tf;
   logic [15:0]         newb, oldb;

   assign p = PLAYER_W'(32'(player) % PLAYERS);
   assign q_push = push && !q_full;

   always_comb begin
      oldb = btn_ff[p];
      newb = buttons & BTN_MASK;
      lt = left_trigger != 8'd0;
      rt = right_trigger != 8'd0;
      tf = {rt && !trg_ff[p][1], rt, lt && !trg_ff[p][0], lt};
      if (poll_ok) begin
         btn_in = newb;
         trg_in = {rt, lt};
         stk_in = {right_y, right_x, left_y, left_x};
         edg_in = {tf, oldb & ~newb, ~oldb & newb};
      end else begin
         btn_in = btn_ff[p];
         trg_in = trg_ff[p];
         stk_in = stk_ff[p];
         edg_in = edg_ff[p];
      end
      q_item.owner = player;
      q_item.buttons = btn_in;
      q_item.press_edge = edg_in[15:0];
      q_item.release_edge = edg_in[31:16];
      q_item.trig_flags = edg_in[35:32];
      q_item.sticks = stk_in;
      q_item.elapsed = elapsed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PLAYERS; i++) begin
            btn_ff[i] <= '0;
            stk_ff[i] <= '0;
            trg_ff[i] <= '0;
            edg_ff[i] <= '0;
         end
      end else if (q_push) begin
         btn_ff[p] <= btn_in;
         stk_ff[p] <= stk_in;
         trg_ff[p] <= trg_in;
         edg_ff[p] <= edg_in;
      end
   end

endmodule

// ===== rtl/gic_queue.sv =====
// Two-entry queue between front and back ends.
// Depends on gic_pkg for the item type.
module gic_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  gic_pkg::gic_item_type push_item,
   output logic                  full,
   input  logic                  pop,
   output logic                  empty,
   output gic_pkg::gic_item_type pop_item
);
   import gic_pkg::*;

   gic_item_type slot_ff [2];
   logic         wr_ff, wr_in;
   logic         rd_ff, rd_in;
   logic [1:0]   cnt_ff, cnt_in;

   assign full = cnt_ff == 2'd2;
   assign empty = cnt_ff == 2'd0;
   assign pop_item = slot_ff[rd_ff];

   always_comb begin
      wr_in = push ? !wr_ff : wr_ff;
      rd_in = pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/gic_back.sv =====
// Back end: dead-zone rescaling by restoring division, hold timers and taps.
// Depends on gic_pkg; drains gic_queue and holds the result register.
module gic_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [15:0]           dead_zone,
   input  logic [15:0]           tap_limit,
   input  logic                  q_empty,
   input  gic_pkg::gic_item_type q_item,
   output logic                  q_pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [1:0]            rsp_owner,
   output logic [15:0]           rsp_press_mask,
   output logic [15:0]           rsp_press_edge_mask,
   output logic [15:0]           rsp_release_mask,
   output logic [3:0]            rsp_trigger_flags,
   output logic signed [15:0]    rsp_left_x_ratio,
   output logic signed [15:0]    rsp_left_y_ratio,
   output logic signed [15:0]    rsp_right_x_ratio,
   output logic signed [15:0]    rsp_right_y_ratio,
   output logic [3:0]            rsp_stick_edge_flags,
   output logic [15:0]           rsp_tap_mask
);
   import gic_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_LOAD = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   gic_item_type       work_ff, work_in;
   logic [1:0]         axis_ff, axis_in;
   logic [3:0]         step_ff, step_in;
   logic [47:0]        rem_ff, rem_in;
   logic [31:0]        den_ff, den_in;
   logic               neg_ff, neg_in;
   logic [14:0]        q_ff, q_in;
   logic [3:0][15:0]   ratio_ff, ratio_in;
   logic [3:0]         defl_ff, defl_in;
   logic [3:0]         deflected_ff [PLAYERS];

   logic [BTN_W:0]     ti_ff, ti_in;
   logic               tp_ff, tp_in;
   logic [BTN_W-1:0]   tk_ff, tk_in;
   logic [15:0]        rd_data_ff;
   logic               rd_vld_ff;
   logic [15:0]        taps_ff, taps_in;
   logic [TMR_DEPTH-1:0] valid_ff;
   logic [15:0]        tmr_mem [TMR_DEPTH];

   logic               out_valid_ff;
   logic               out_load;

   logic [PLAYER_W-1:0] p;
   logic [15:0]        raw;
   logic [16:0]        mag, wdz;
   logic [30:0]        dzd;
   logic [32:0]        scaled, num;
   logic [31:0]        den;
   logic               outside;
   logic [47:0]        trial;
   logic               ge;
   logic [14:0]        qbit, qfin;
   logic               timers_done;
   logic [TMR_AW-1:0]  rd_addr, wr_addr;
   logic               rd_en;
   logic [15:0]        t_cur, t_new;
   logic [16:0]        t_sum;

   assign p = PLAYER_W'(32'(work_ff.owner) % PLAYERS);
   assign timers_done = (ti_ff == (BTN_W+1)'(BUTTONS)) && !tp_ff;
   assign rsp_empty = !out_valid_ff;
   assign out_load = (state_ff == ST_DONE) && timers_done && (!out_valid_ff || rsp_pop);

   // axis set-up and divider step
   always_comb begin
      raw = work_ff.sticks[axis_ff];
      mag = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
      dzd = {dead_zone, 15'd0} - {15'd0, dead_zone};
      scaled = {mag, 16'd0};
      outside = scaled > {2'd0, dzd};
      num = scaled - {2'd0, dzd};
      wdz = 17'h10000 - {1'b0, dead_zone};
      den = {wdz, 15'd0} - {15'd0, wdz};
      trial = {16'd0, den_ff} << step_ff;
      ge = rem_ff >= trial;
      qbit = 15'd1 << step_ff;
      qfin = ge ? (q_ff | qbit) : q_ff;
   end

   // axis sequencer
   always_comb begin
      state_in = state_ff;
      work_in = work_ff;
      axis_in = axis_ff;
      step_in = step_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      q_in = q_ff;
      ratio_in = ratio_ff;
      defl_in = defl_ff;
      q_pop = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               work_in = q_item;
               axis_in = 2'd0;
               defl_in = 4'd0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (outside) begin
               defl_in[axis_ff] = 1'b1;
               rem_in = {num, 15'd0} + {16'd0, 1'b0, den[31:1]};
               den_in = den;
               neg_in = raw[15];
               q_in = 15'd0;
               step_in = 4'd15;
               state_in = ST_DIV;
            end else begin
               ratio_in[axis_ff] = 16'd0;
               axis_in = axis_ff + 2'd1;
               state_in = (axis_ff == 2'd3) ? ST_DONE : ST_LOAD;
            end
         end
         ST_DIV: begin
            if (step_ff == 4'd15 && ge) begin
               ratio_in[axis_ff] = neg_ff ? 16'h8001 : 16'h7fff;
               axis_in = axis_ff + 2'd1;
               state_in = (axis_ff == 2'd3) ? ST_DONE : ST_LOAD;
            end else begin
               if (ge) begin
                  rem_in = rem_ff - trial;
               end
               q_in = qfin;
               step_in = step_ff - 4'd1;
               if (step_ff == 4'd0) begin
                  ratio_in[axis_ff] = neg_ff ? (16'd0 - {1'b0, qfin}) : {1'b0, qfin};
                  axis_in = axis_ff + 2'd1;
                  state_in = (axis_ff == 2'd3) ? ST_DONE : ST_LOAD;
               end
            end
         end
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold-timer sweep, one button per cycle
   always_comb begin
      ti_in = ti_ff;
      tp_in = 1'b0;
      tk_in = tk_ff;
      taps_in = taps_ff;
      rd_en = 1'b0;
      rd_addr = TMR_AW'(32'(p) * BUTTONS + 32'(ti_ff[BTN_W-1:0]));
      wr_addr = TMR_AW'(32'(p) * BUTTONS + 32'(tk_ff));
      t_cur = rd_vld_ff ? rd_data_ff : 16'd0;
      t_sum = {1'b0, t_cur} + {1'b0, work_ff.elapsed};
      t_new = work_ff.buttons[tk_ff] ? (t_sum[16] ? 16'hffff : t_sum[15:0]) : 16'd0;
      if (state_ff == ST_IDLE) begin
         if (!q_empty) begin
            ti_in = '0;
            taps_in = 16'd0;
         end
      end else if (ti_ff != (BTN_W+1)'(BUTTONS)) begin
         rd_en = 1'b1;
         tp_in = 1'b1;
         tk_in = ti_ff[BTN_W-1:0];
         ti_in = ti_ff + (BTN_W+1)'(1);
      end
      if (tp_ff && work_ff.release_edge[tk_ff] && (t_cur <= tap_limit)) begin
         taps_in[tk_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ti_ff <= (BTN_W+1)'(BUTTONS);
         tp_ff <= 1'b0;
         valid_ff <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < PLAYERS; i++) begin
            deflected_ff[i] <= 4'd0;
         end
      end else begin
         state_ff <= state_in;
         ti_ff <= ti_in;
         tp_ff <= tp_in;
         if (tp_ff) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
            deflected_ff[p] <= defl_ff;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      axis_ff <= axis_in;
      step_ff <= step_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      q_ff <= q_in;
      ratio_ff <= ratio_in;
      defl_ff <= defl_in;
      tk_ff <= tk_in;
      taps_ff <= taps_in;
   end

   // timer memory: registered read, written back in the cycle after the read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= tmr_mem[rd_addr];
         rd_vld_ff <= valid_ff[rd_addr];
      end
      if (tp_ff) begin
         tmr_mem[wr_addr] <= t_new;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_owner <= work_ff.owner;
         rsp_press_mask <= work_ff.buttons;
         rsp_press_edge_mask <= work_ff.press_edge;
         rsp_release_mask <= work_ff.release_edge;
         rsp_trigger_flags <= work_ff.trig_flags;
         rsp_left_x_ratio <= ratio_ff[0];
         rsp_left_y_ratio <= ratio_ff[1];
         rsp_right_x_ratio <= ratio_ff[2];
         rsp_right_y_ratio <= ratio_ff[3];
         rsp_stick_edge_flags <= defl_ff & ~deflected_ff[p];
         rsp_tap_mask <= (tap_limit == 16'd0) ? BTN_MASK : taps_ff;
      end
   end

endmodule

// ===== tb/gic_result_checker.sv =====
// Checker for the gamepad input conditioner: watches the poll and result channels,
// predicts every result and counts mismatches. Depends on gic_pkg only.
module gic_result_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  logic               req_full,
   input  logic [1:0]         req_player,
   input  logic               req_poll_ok,
   input  logic [15:0]        req_buttons,
   input  logic [7:0]         req_left_trigger,
   input  logic [7:0]         req_right_trigger,
   input  logic signed [15:0] req_left_x,
   input  logic signed [15:0] req_left_y,
   input  logic signed [15:0] req_right_x,
   input  logic signed [15:0] req_right_y,
   input  logic [15:0]        req_elapsed,
   input  logic               rsp_empty,
   input  logic               rsp_pop,
   input  logic [1:0]         rsp_owner,
   input  logic [15:0]        rsp_press_mask,
   input  logic [15:0]        rsp_press_edge_mask,
   input  logic [15:0]        rsp_release_mask,
   input  logic [3:0]         rsp_trigger_flags,
   input  logic signed [15:0] rsp_left_x_ratio,
   input  logic signed [15:0] rsp_left_y_ratio,
   input  logic signed [15:0] rsp_right_x_ratio,
   input  logic signed [15:0] rsp_right_y_ratio,
   input  logic [3:0]         rsp_stick_edge_flags,
   input  logic [15:0]        rsp_tap_mask,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [15:0]        csr_wdata,
   output int                 fail_count,
   output int                 pending_count
);
   import gic_pkg::*;

   typedef struct packed {
      logic [1:0]       owner;
      logic [15:0]      press;
      logic [15:0]      press_edge;
      logic [15:0]      release_edge;
      logic [3:0]       trig;
      logic [3:0][15:0] ratio;
      logic [3:0]       stick_edge;
      logic [15:0]      tap;
   } conditioned_poll_type;

   conditioned_poll_type expected_polls[$];
   logic [15:0]      dz_frac, tap_hold_max;
   logic [15:0]      last_buttons[PLAYERS];
   logic [3:0][15:0] last_sticks[PLAYERS];
   logic [1:0]       last_trig[PLAYERS];
   logic [15:0]      last_press_edge[PLAYERS];
   logic [15:0]      last_release[PLAYERS];
   logic [3:0]       last_trig_flags[PLAYERS];
   logic [3:0]       deflected[PLAYERS];
   logic [15:0]      hold_time[PLAYERS][BUTTONS];

   function automatic logic [15:0] dead_zone_ratio(input logic [15:0] raw,
                                                   output logic outside);
      logic [63:0] mag, thr, num, den, q;
      mag = raw[15] ? 64'(17'h10000 - raw) : 64'(raw);
      thr = 64'd32767 * dz_frac;
      outside = 1'b0;
      if ((mag << 16) <= thr) return 16'd0;
      outside = 1'b1;
      num = (mag << 16) - thr;
      den = 64'd32767 * (64'd65536 - dz_frac);
      q = (num * 64'd32768 + den / 2) / den;
      if (q > 64'd32767) q = 64'd32767;
      return raw[15] ? 16'(17'h10000 - q) : q[15:0];
   endfunction

   task automatic condition_poll();
      conditioned_poll_type c;
      int p;
      logic lt, rt, o;
      logic [3:0] tf, defl;
      logic [16:0] t;
      p = req_player % PLAYERS;
      if (req_poll_ok) begin
         lt = req_left_trigger != 0;
         rt = req_right_trigger != 0;
         tf = {rt && !last_trig[p][1], rt, lt && !last_trig[p][0], lt};
         last_press_edge[p] = ~last_buttons[p] & req_buttons & BTN_MASK;
         last_release[p] = last_buttons[p] & ~req_buttons & BTN_MASK;
         last_trig_flags[p] = tf;
         last_buttons[p] = req_buttons & BTN_MASK;
         last_trig[p] = {rt, lt};
         last_sticks[p] = {req_right_y, req_right_x, req_left_y, req_left_x};
      end
      for (int k = 0; k < 4; k++) begin
         c.ratio[k] = dead_zone_ratio(last_sticks[p][k], o);
         defl[k] = o;
      end
      c.stick_edge = defl & ~deflected[p];
      deflected[p] = defl;
      c.tap = '0;
      for (int k = 0; k < BUTTONS; k++) begin
         if (last_release[p][k] && hold_time[p][k] <= tap_hold_max) c.tap[k] = 1'b1;
         t = 17'(hold_time[p][k]) + 17'(req_elapsed);
         hold_time[p][k] = !last_buttons[p][k] ? 16'd0 : (t[16] ? 16'hFFFF : t[15:0]);
      end
      if (tap_hold_max == 0) c.tap = BTN_MASK;
      c.owner = req_player;
      c.press = last_buttons[p];
      c.press_edge = last_press_edge[p];
      c.release_edge = last_release[p];
      c.trig = last_trig_flags[p];
      expected_polls.push_back(c);
   endtask

   task automatic compare_field(input string name, input logic [15:0] exp_v,
                                input logic [15:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      conditioned_poll_type e;
      if (reset) begin
         dz_frac <= DEAD_ZONE_RESET;
         tap_hold_max <= TAP_LIMIT_RESET;
         for (int p = 0; p < PLAYERS; p++) begin
            last_buttons[p] = '0; last_sticks[p] = '0; last_trig[p] = '0;
            last_press_edge[p] = '0; last_release[p] = '0; last_trig_flags[p] = '0;
            deflected[p] = '0;
            for (int k = 0; k < BUTTONS; k++) hold_time[p][k] = '0;
         end
         expected_polls.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == REG_DEAD_ZONE) dz_frac <= csr_wdata;
            else tap_hold_max <= csr_wdata;
         end
         if (req_push && !req_full) condition_poll();
         if (rsp_pop && !rsp_empty) begin
            if (expected_polls.size() == 0) begin
               $display("%0t unexpected result: expected none actual owner %h",
                        $time, rsp_owner);
               fail_count++;
            end else begin
               e = expected_polls.pop_front();
               compare_field("owner", 16'(e.owner), 16'(rsp_owner));
               compare_field("press_mask", e.press, rsp_press_mask);
               compare_field("press_edge_mask", e.press_edge, rsp_press_edge_mask);
               compare_field("release_mask", e.release_edge, rsp_release_mask);
               compare_field("trigger_flags", 16'(e.trig), 16'(rsp_trigger_flags));
               compare_field("left_x_ratio", e.ratio[0], rsp_left_x_ratio);
               compare_field("left_y_ratio", e.ratio[1], rsp_left_y_ratio);
               compare_field("right_x_ratio", e.ratio[2], rsp_right_x_ratio);
               compare_field("right_y_ratio", e.ratio[3], rsp_right_y_ratio);
               compare_field("stick_edge_flags", 16'(e.stick_edge),
                             16'(rsp_stick_edge_flags));
               compare_field("tap_mask", e.tap, rsp_tap_mask);
            end
         end
      end
      pending_count = expected_polls.size();
   end

   initial begin
      fail_count = 0;
      pending_count = 0;
   end

endmodule

// ===== tb/gamepad_input_conditioner_test.sv =====
// Stimulus and verdict for the gamepad input conditioner: directed and random polls
// through several register settings. Depends on gic_pkg, gic_result_checker and the block.
module gamepad_input_conditioner_test;
   import gic_pkg::*;

   localparam int STALL_LIMIT = 20000;

   logic               clock, reset;
   logic               req_push, req_full, req_poll_ok;
   logic [1:0]         req_player;
   logic [15:0]        req_buttons, req_elapsed;
   logic [7:0]         req_left_trigger, req_right_trigger;
   logic signed [15:0] req_left_x, req_left_y, req_right_x, req_right_y;
   logic               rsp_empty, rsp_pop;
   logic [1:0]         rsp_owner;
   logic [15:0]        rsp_press_mask, rsp_press_edge_mask, rsp_release_mask, rsp_tap_mask;
   logic [3:0]         rsp_trigger_flags, rsp_stick_edge_flags;
   logic signed [15:0] rsp_left_x_ratio, rsp_left_y_ratio, rsp_right_x_ratio;
   logic signed [15:0] rsp_right_y_ratio;
   logic               csr_we, csr_index;
   logic [15:0]        csr_wdata;
   int                 fail_count, pending_count, quiet_cycles;
   logic               hold_off, stim_done;

   gamepad_input_conditioner u_top (.*);
   gic_result_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic logic [15:0] axis_value();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'($urandom_range(0, 12000));
         4: return -16'($urandom_range(0, 12000));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_poll(input logic [1:0] pl, input logic ok, input logic [15:0] btn,
                            input logic [7:0] lt, input logic [7:0] rt,
                            input logic [3:0][15:0] ax, input logic [15:0] el,
                            input bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_player <= pl; req_poll_ok <= ok; req_buttons <= btn;
      req_left_trigger <= lt; req_right_trigger <= rt;
      req_left_x <= ax[0]; req_left_y <= ax[1]; req_right_x <= ax[2]; req_right_y <= ax[3];
      req_elapsed <= el;
      do @(posedge clock); while (req_full);
   endtask

   task automatic random_poll(input bit no_gap);
      logic [3:0][15:0] ax;
      logic [15:0] el;
      for (int k = 0; k < 4; k++) ax[k] = axis_value();
      el = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
      send_poll(2'($urandom), $urandom_range(0, 5) != 0,
                ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15)),
                ($urandom_range(0, 1)) ? 8'($urandom) : 8'd0,
                ($urandom_range(0, 1)) ? 8'($urandom) : 8'd0, ax, el, no_gap);
   endtask

   task automatic drain();
      req_push <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_regs(input logic [15:0] dz, input logic [15:0] tl);
      csr_we <= 1'b1; csr_index <= REG_DEAD_ZONE; csr_wdata <= dz;
      @(posedge clock);
      csr_index <= REG_TAP_LIMIT; csr_wdata <= tl;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      logic [15:0] dz_set[5];
      logic [15:0] tap_set[5];
      dz_set = '{16'd0, 16'hFFFF, 16'd13107, 16'd1, 16'($urandom)};
      tap_set = '{16'd40, 16'hFFFF, 16'd0, 16'd1, 16'($urandom_range(2, 200))};
      reset = 1'b1; req_push = 0; req_player = 0; req_poll_ok = 0; req_buttons = 0;
      req_left_trigger = 0; req_right_trigger = 0; req_left_x = 0; req_left_y = 0;
      req_right_x = 0; req_right_y = 0; req_elapsed = 0;
      csr_we = 0; csr_index = REG_DEAD_ZONE; csr_wdata = 0; stim_done = 0; hold_off = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: extremes, edges, failed polls, timer saturation
      send_poll(0, 1, 16'hFFFF, 8'hFF, 8'hFF, {16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF},
                16'hFFFF, 0);
      send_poll(0, 1, 16'hFFFF, 8'hFF, 8'h00, {16'h7FFF, 16'h8000, 16'd6553, 16'd6554},
                16'hFFFF, 0);
      send_poll(0, 0, 16'h0000, 8'h00, 8'h00, '0, 16'd5, 0);
      send_poll(0, 1, 16'h0000, 8'h00, 8'h01, '0, 16'd0, 0);
      send_poll(0, 0, 16'h1234, 8'h01, 8'h01, '0, 16'd1, 0);
      send_poll(1, 1, 16'hA5A5, 8'h80, 8'h00, {16'd1, -16'sd1, 16'd32000, -16'sd32000},
                16'd3, 0);
      send_poll(1, 1, 16'h5A5A, 8'h00, 8'h80, '0, 16'd0, 0);
      send_poll(3, 1, 16'h0001, 8'h00, 8'h00, {4{16'h7FFF}}, 16'd1, 0);
      send_poll(3, 1, 16'h0000, 8'h00, 8'h00, {4{16'h8000}}, 16'd0, 0);
      drain();
      for (int ph = 0; ph < 5; ph++) begin
         write_regs(dz_set[ph], tap_set[ph]);
         for (int n = 0; n < 20; n++) random_poll(0);
         // long receiver hold-off while polls keep coming
         if (ph == 1) begin
            hold_off <= 1'b1;
            for (int n = 0; n < 6; n++) random_poll(1);
            hold_off <= 1'b0;
         end
         for (int n = 0; n < 330; n++) random_poll(n % 50 < 10);
         drain();
      end
      stim_done <= 1'b1;
   end

   initial begin
      int wait_cycles;
      rsp_pop = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_off) begin
            rsp_pop <= 1'b0;
            repeat (600) @(posedge clock);
         end
         wait_cycles = $urandom_range(0, 17);
         if (wait_cycles != 0) begin
            rsp_pop <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_we)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      quiet_cycles = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (stim_done) begin
            if (fail_count == 0 && pending_count == 0)
               $display("PASS");
            else
               $display("FAIL");
            $finish;
         end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

endmodule
